@@ src/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types, codes and the microcode table of the decimal text converter
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  // sequencer step codes
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] ST_SIGN   = 3'd1;
  localparam logic [STEP_W-1:0] ST_DABBLE = 3'd2;
  localparam logic [STEP_W-1:0] ST_SKIP   = 3'd3;
  localparam logic [STEP_W-1:0] ST_EMIT   = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SIGN,
    OP_DABBLE,
    OP_SKIP,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_TRUE,
    C_START,
    C_BITS,
    C_LEAD,
    C_MORE
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] tgt_t;
    logic [STEP_W-1:0] tgt_f;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic start;
    logic bits_more;
    logic lead_zero;
    logic digits_more;
  } flags_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      ST_IDLE:   w = '{op: OP_LOAD,   cond: C_START, tgt_t: ST_SIGN,   tgt_f: ST_IDLE};
      ST_SIGN:   w = '{op: OP_SIGN,   cond: C_TRUE,  tgt_t: ST_DABBLE, tgt_f: ST_DABBLE};
      ST_DABBLE: w = '{op: OP_DABBLE, cond: C_BITS,  tgt_t: ST_DABBLE, tgt_f: ST_SKIP};
      ST_SKIP:   w = '{op: OP_SKIP,   cond: C_LEAD,  tgt_t: ST_SKIP,   tgt_f: ST_EMIT};
      ST_EMIT:   w = '{op: OP_EMIT,   cond: C_MORE,  tgt_t: ST_EMIT,   tgt_f: ST_IDLE};
      default:   w = '{op: OP_NOP,    cond: C_TRUE,  tgt_t: ST_IDLE,   tgt_f: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ src/itoa_useq.sv @@
// ----------------------------------------------------------------------------
// itoa_useq
// step counter over the microcode table, with conditional two-way jumps
// ----------------------------------------------------------------------------
module itoa_useq
  import itoa_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o,
  output logic   busy_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              take;

  assign ctrl_o = ucode(step_q);
  assign busy_o = (step_q != ST_IDLE);

  always_comb begin
    case (ctrl_o.cond)
      C_TRUE:  take = 1'b1;
      C_START: take = flags_i.start;
      C_BITS:  take = flags_i.bits_more;
      C_LEAD:  take = flags_i.lead_zero;
      C_MORE:  take = flags_i.digits_more;
      default: take = 1'b0;
    endcase
    step_d = take ? ctrl_o.tgt_t : ctrl_o.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

@@ src/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed integer to decimal ascii text, most significant character first
// ----------------------------------------------------------------------------
//
//  channel   signals                        direction  handshake
//  --------  -----------------------------  ---------  -----------------------
//  item in   start_i, busy_o, value_i       in         taken at start_i & !busy_o
//  chars out strobe_o, char_code_o, last_o  out        one cycle per char, no stall
//
// steps: accept, sign, VALUE_BITS double-dabble shifts, one skip per leading
//   zero digit plus one step to find the first digit, one emit per digit;
//   skips and emitted digits always add up to NUM_DIGITS
// busy_o stays high from the cycle after accept until the last character
//   has been handed to the output register
// reset clears the step counter, the bit counter and the strobe, and sets the digit counter to one
// the receiver cannot stall: every strobe is a delivered character
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         strobe_o,
  output logic [7:0]                   char_code_o,
  output logic                         last_o
);

  // decimal digits of 2^(VALUE_BITS-1); 1233/4096 approximates log10(2)
  localparam int unsigned NUM_DIGITS = (((VALUE_BITS - 1) * 1233) >> 12) + 1;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned BIT_W      = $clog2(VALUE_BITS);
  localparam int unsigned DIG_W      = $clog2(NUM_DIGITS + 1);

  ctrl_t  ctrl;
  flags_t flags;

  // datapath registers
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic                  neg_q, neg_d;
  logic [BIT_W-1:0]      bcnt_q, bcnt_d;
  logic [DIG_W-1:0]      dcnt_q, dcnt_d;

  // output register
  logic       strobe_q, strobe_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;

  logic [BCD_W-1:0] bcd_adj;
  logic [3:0]       top_digit;
  logic             lead_zero;

  itoa_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  assign top_digit = bcd_q[BCD_W-1 -: 4];
  // only skip zeros while more than one digit is left, so zero prints as '0'
  assign lead_zero = (top_digit == 4'd0) && (dcnt_q != DIG_W'(1));

  assign flags.start       = start_i;
  assign flags.bits_more   = (bcnt_q != '0);
  assign flags.lead_zero   = lead_zero;
  assign flags.digits_more = (dcnt_q != DIG_W'(1));

  // add-3 correction on each bcd digit before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    neg_d    = neg_q;
    bcnt_d   = bcnt_q;
    dcnt_d   = dcnt_q;
    strobe_d = 1'b0;
    char_d   = char_q;
    last_d   = last_q;
    case (ctrl.op)
      OP_LOAD: begin
        // magnitude of the most negative value still fits as unsigned
        neg_d  = value_i[VALUE_BITS-1];
        mag_d  = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;
        bcd_d  = '0;
        bcnt_d = BIT_W'(VALUE_BITS - 1);
        dcnt_d = DIG_W'(NUM_DIGITS);
      end
      OP_SIGN: begin
        strobe_d = neg_q;
        char_d   = CH_MINUS;
        last_d   = 1'b0;
      end
      OP_DABBLE: begin
        bcd_d  = {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
        mag_d  = {mag_q[VALUE_BITS-2:0], 1'b0};
        bcnt_d = bcnt_q - 1'b1;
      end
      OP_SKIP: begin
        if (lead_zero) begin
          bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      OP_EMIT: begin
        strobe_d = 1'b1;
        char_d   = CH_ZERO + {4'd0, top_digit};
        last_d   = (dcnt_q == DIG_W'(1));
        bcd_d    = {bcd_q[BCD_W-5:0], 4'd0};
        dcnt_d   = dcnt_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      bcnt_q   <= '0;
      dcnt_q   <= DIG_W'(1);
    end else begin
      strobe_q <= strobe_d;
      bcnt_q   <= bcnt_d;
      dcnt_q   <= dcnt_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign strobe_o    = strobe_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  // an accepted item always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not raise busy");

  // the final character ends the run: no character right behind it
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("character emitted right after last");

  // a character seen while idle can only be the closing one of a run
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !busy_o |-> last_o)
    else $error("non-final character while idle");

  // only a minus sign or a decimal digit is ever emitted
  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (char_code_o == CH_MINUS) ||
                 ((char_code_o >= CH_ZERO) && (char_code_o <= CH_ZERO + 8'd9)))
    else $error("bad character code");

endmodule

@@ tb/itoa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_checker
// watches the value and character channels, predicts the decimal text of
// each accepted item and compares every strobed character against it
// ----------------------------------------------------------------------------
module itoa_checker
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  strobe_i,
  input  logic [7:0]            char_code_i,
  input  logic                  last_i,
  output int                    mismatch_count_o,
  output int                    chars_pending_o
);

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  text_char_t expected_chars[$];

  // decimal text of one value, sign first, digits most significant first
  function automatic void predict_decimal_text(input logic [VALUE_BITS-1:0] value);
    logic [63:0]  magnitude;
    logic [3:0]   digits[21];
    int           n_digits;
    text_char_t   ch;
    n_digits  = 0;
    magnitude = '0;
    if (value[VALUE_BITS-1]) begin
      magnitude[VALUE_BITS-1:0] = ~value + 1'b1;
      ch.code = CH_MINUS;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
    end else begin
      magnitude[VALUE_BITS-1:0] = value;
    end
    do begin
      digits[n_digits] = 4'(magnitude % 64'd10);
      n_digits++;
      magnitude = magnitude / 64'd10;
    end while (magnitude != 0);
    for (int i = n_digits - 1; i >= 0; i--) begin
      ch.code = CH_ZERO + 8'(digits[i]);
      ch.last = (i == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      mismatch_count_o = 0;
    end else begin
      if (start_i && !busy_i) predict_decimal_text(value_i);
      if (strobe_i) begin
        if (expected_chars.size() == 0) begin
          $error("character %0d with no item pending", char_code_i);
          mismatch_count_o++;
        end else begin
          want = expected_chars.pop_front();
          if (char_code_i !== want.code) begin
            $error("char_code: expected %0d, got %0d", want.code, char_code_i);
            mismatch_count_o++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_i);
            mismatch_count_o++;
          end
        end
      end
    end
    chars_pending_o = expected_chars.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the signed integer to decimal text converter:
// directed corner values, then random values of every size and sign, with
// random start gaps; all checking happens in the checker beside the block
// ----------------------------------------------------------------------------
module testbench
  import itoa_pkg::*;
();

  localparam int unsigned VB          = VALUE_BITS_DEF;
  localparam int          N_RANDOM    = 200;
  localparam int          N_STEADY    = 40;       // final items sent back to back
  localparam int          DRAIN       = 60;       // quiet cycles after the last char
  localparam longint      CYCLE_LIMIT = 200_000;

  logic          clk_i   = 1'b0;
  logic          rst_ni  = 1'b0;
  logic          start_i = 1'b0;
  logic [VB-1:0] value_i = '0;
  logic          busy_o;
  logic          strobe_o;
  logic [7:0]    char_code_o;
  logic          last_o;

  int            mismatch_count;
  int            chars_pending;
  longint        cycle_count = 0;

  // 2 ns period
  always #1 clk_i = ~clk_i;

  signed_int_to_decimal_ascii #(.VALUE_BITS(VB)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  itoa_checker #(.VALUE_BITS(VB)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .value_i          (value_i),
    .strobe_i         (strobe_o),
    .char_code_i      (char_code_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatch_count),
    .chars_pending_o  (chars_pending)
  );

  // hard stop if the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("signed_int_to_decimal_ascii verification failed");
      $finish;
    end
  end

  // raise start with a new item at a rising edge and hold it until the
  // block takes it; busy_o is sampled at the falling edge, where it is
  // stable, so the following rising edge is the accepting one
  task automatic send_value(input logic [VB-1:0] v, input bit allow_gap);
    int gap;
    start_i <= 1'b1;
    value_i <= v;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
    // optional idle burst between items
    if (allow_gap && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 17);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // random value: full-range bits, or a tiny number, a chosen digit count or a
  // power-of-ten boundary, each of the last three with a random sign
  function automatic logic [VB-1:0] random_value();
    longint p10;
    longint mag;
    int     n_digits;
    case ($urandom_range(0, 3))
      0: return VB'({$urandom(), $urandom()});
      1: mag = $urandom_range(0, 99);
      2: begin
        n_digits = $urandom_range(1, 10);
        p10 = 1;
        repeat (n_digits) p10 = p10 * 10;
        mag = longint'({$urandom(), $urandom()} % 64'(p10));
      end
      default: begin
        n_digits = $urandom_range(1, 9);
        p10 = 1;
        repeat (n_digits) p10 = p10 * 10;
        mag = p10 + $urandom_range(0, 2) - 1;
      end
    endcase
    if ($urandom_range(0, 1)) mag = -mag;
    return VB'(mag);
  endfunction

  logic [VB-1:0] corner_values[$];

  initial begin
    // corners: zero, single digits, several digit-count boundaries, both limits,
    // the most negative value, alternating bit patterns
    corner_values = '{
      VB'(0), VB'(1), VB'(-1), VB'(9), VB'(-9), VB'(10), VB'(-10), VB'(99),
      VB'(100), VB'(-100), VB'(999_999_999), VB'(1_000_000_000),
      VB'(-1_000_000_000), VB'(2_147_483_647), VB'(-2_147_483_647),
      {1'b1, {(VB-1){1'b0}}}, VB'(123_456_789), VB'(-987_654_321),
      VB'(32'h5555_5555), VB'(32'hAAAA_AAAA), VB'(7), VB'(-5)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_values[i]) send_value(corner_values[i], 1'b1);
    for (int i = 0; i < N_RANDOM; i++) begin
      send_value(random_value(), i < N_RANDOM - N_STEADY);
    end
    start_i <= 1'b0;

    // drain: every predicted character has to come out
    forever begin
      @(negedge clk_i);
      if (chars_pending == 0) break;
    end
    repeat (DRAIN) @(posedge clk_i);

    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("signed_int_to_decimal_ascii verification clean");
    end else begin
      $display("signed_int_to_decimal_ascii verification failed");
    end
    $finish;
  end

endmodule
